[hdl/multi_mode_saturation_waveshaper_unit_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the saturation waveshaper
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_SATURATION_WAVESHAPER_UNIT_ASSERT_SVH
`define MULTI_MODE_SATURATION_WAVESHAPER_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define MMSW_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("waveshaper assertion failed");

// condition implies consequence in the next cycle
`define MMSW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("waveshaper assertion failed");

`endif

[hdl/mmsw_pkg.sv]
// ----------------------------------------------------------------------------
// mmsw_pkg
// codes and fixed widths shared by the saturation waveshaper
// ----------------------------------------------------------------------------
`default_nettype none

package mmsw_pkg;

	localparam int MODE_W    = 3;
	localparam int GAIN_W    = 16;
	localparam int CFG_W     = 16;
	localparam int GAIN_FRAC = 12;

	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [GAIN_W-1:0] gain_t;
	typedef logic [0:0]        reg_idx_t;

	localparam mode_t MODE_SOFT = 3'd0;
	localparam mode_t MODE_HARD = 3'd1;
	localparam mode_t MODE_TUBE = 3'd2;
	localparam mode_t MODE_TAPE = 3'd3;

	localparam reg_idx_t REG_CURVE_MODE = 1'b0;
	localparam reg_idx_t REG_DRIVE_GAIN = 1'b1;

	localparam gain_t GAIN_UNITY = 16'd4096;

endpackage

`default_nettype wire

[hdl/multi_mode_saturation_waveshaper_unit.sv]
// ----------------------------------------------------------------------------
// multi_mode_saturation_waveshaper_unit
// drive gain followed by one of four odd-symmetric clipping curves or a bypass
//
//   channel | signals                          | direction
//   input   | in_valid, in_stall, sample_in    | beat in
//   output  | out_valid, out_stall, sample_out | beat out
//   config  | cfg_we, cfg_addr, cfg_wdata      | register write
//
// one beat per cycle sustained while out_stall is low; the pipeline length is
// set by the bit-per-stage soft clip divider
// every stage holds only when it and all stages after it are full
// reset clears valid bits and sets curve_mode 0, drive_gain unity
// ----------------------------------------------------------------------------
`default_nettype none

module multi_mode_saturation_waveshaper_unit #(
	parameter int SAMPLE_BITS      = 16,
	parameter int TANH_TABLE_DEPTH = 256
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  signed [SAMPLE_BITS-1:0] sample_in,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  wire                          cfg_we,
	input  mmsw_pkg::reg_idx_t           cfg_addr,
	input  wire  [mmsw_pkg::CFG_W-1:0]   cfg_wdata
);
	import mmsw_pkg::*;

	localparam int S    = SAMPLE_BITS;
	localparam int D    = TANH_TABLE_DEPTH;
	localparam int F    = S - 1;
	localparam int PRW  = S + GAIN_W;
	localparam int DW   = S + 5;
	localparam int EW   = S + 1;
	localparam int DENW = S + 3;
	localparam int NW   = 2 * F + 3;
	localparam int QB   = F;
	localparam int RW   = $clog2(D + 1);
	localparam int PW   = DW + $clog2(D) + 1;
	localparam int IW   = PW - F - 2;
	localparam int FRW  = F + 2;
	localparam int K3   = F + 4;
	localparam int P3W  = F + 2 + K3;
	localparam int TPW  = S + FRW;
	localparam int NST  = 7 + QB;

	localparam longint unsigned ONE_L  = 64'd1 << F;
	localparam longint unsigned T_L    = (7 * ONE_L + 5) / 10;
	localparam longint unsigned H_L    = (19 * ONE_L + 10) / 20;
	localparam longint unsigned TCAP_L = (2 * ONE_L + 1) / 3;
	localparam longint unsigned M3_L   = ((64'd1 << K3) + 2) / 3;

	localparam logic [DW-1:0]  ONE_D  = ONE_L[DW-1:0];
	localparam logic [DW-1:0]  MAX_D  = ONE_D - DW'(1);
	localparam logic [DW-1:0]  T_D    = T_L[DW-1:0];
	localparam logic [DW-1:0]  H_D    = H_L[DW-1:0];
	localparam logic [DW-1:0]  TCAP_D = TCAP_L[DW-1:0];
	localparam logic [DW-1:0]  BIG_D  = DW'(3) * ONE_D;
	localparam logic [DW-1:0]  HALF_D = ONE_D >> 1;
	localparam logic [P3W-1:0] M3_P   = M3_L[P3W-1:0];
	localparam logic signed [S-1:0] HPOS_S = H_L[S-1:0];
	localparam logic signed [S-1:0] HNEG_S = -HPOS_S;

	// shift and subtract quotient, used only while building the table
	function automatic longint unsigned udiv(input longint unsigned n,
		input longint unsigned dv);
		longint unsigned q, rm;
		q  = '0;
		rm = '0;
		for (int b = 63; b >= 0; b--) begin
			rm = {rm[62:0], n[b]};
			if (rm >= dv) begin
				rm   = rm - dv;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [(D+1)*S-1:0] build_rom();
		longint unsigned a, term, r, p, num, den, t30, v30, ent;
		logic [(D+1)*S-1:0] rv;
		int k, i;
		rv   = '0;
		a    = udiv(64'd12 << 31, 64'(D));
		term = 64'd1 << 31;
		r    = 64'd1 << 31;
		p    = 64'd1 << 31;
		for (k = 1; k <= 16; k++) begin
			term = udiv((term * a) >> 31, 64'(k));
			if (k[0]) r = r - term;
			else r = r + term;
		end
		for (i = 0; i <= D; i++) begin
			num = (64'd1 << 31) - p;
			den = (64'd1 << 31) + p;
			t30 = udiv(num << 30, den);
			v30 = udiv(t30 * 4 + 2, 64'd5);
			ent = ((v30 << F) + (64'd1 << 29)) >> 30;
			rv[i*S +: S] = ent[S-1:0];
			p = (p * r + (64'd1 << 30)) >> 31;
		end
		return rv;
	endfunction

	localparam logic [(D+1)*S-1:0] TANH_ROM = build_rom();

	// configuration
	mode_t curve_mode_q;
	gain_t drive_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= MODE_SOFT;
			drive_gain_q <= GAIN_UNITY;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CURVE_MODE: curve_mode_q <= cfg_wdata[MODE_W-1:0];
				REG_DRIVE_GAIN: curve_mode_q <= curve_mode_q;
				default:        curve_mode_q <= curve_mode_q;
			endcase
			if (cfg_addr == REG_DRIVE_GAIN) drive_gain_q <= cfg_wdata[GAIN_W-1:0];
		end
	end

	// stage enables: a stage moves when some stage from it onward is empty or the output is not stalled
	logic [NST:1] vld_q;
	logic [NST:1] en;
	logic         last_free;

	always_comb begin
		last_free = !vld_q[NST] || !out_stall;
		for (int i = 1; i <= NST; i++) begin
			en[i] = last_free || !(&(vld_q | NST'((64'd1 << (i - 1)) - 1)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NST; i++) begin
				if (en[i]) vld_q[i] <= (i == 1) ? in_valid : vld_q[(i > 1) ? i - 1 : 1];
			end
		end
	end

	assign in_stall  = !en[1];
	assign out_valid = vld_q[NST];

	// s1: magnitude times drive gain
	logic           neg_s1;
	logic [PRW-1:0] prod_s1;
	logic [S-1:0]   mag;

	assign mag = sample_in[S-1] ? S'(-sample_in) : S'(sample_in);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			neg_s1  <= sample_in[S-1];
			prod_s1 <= PRW'(mag) * PRW'(drive_gain_q);
		end
	end

	// s2: round to driven magnitude
	logic [PRW:0]  rnd;
	logic          neg_s2;
	logic [DW-1:0] d_s2;

	assign rnd = {1'b0, prod_s1} + (PRW+1)'(1 << (GAIN_FRAC - 1));

	always_ff @(posedge clk) begin
		if (en[2]) begin
			neg_s2 <= neg_s1;
			d_s2   <= rnd[PRW:GAIN_FRAC];
		end
	end

	// s3: soft knee operands, tube square, table read
	logic [DW-1:0]   e_full;
	logic [EW-1:0]   e;
	logic [DENW-1:0] den;
	logic [F-1:0]    x;
	logic [PW-1:0]   pos;
	logic [IW-1:0]   idx_full;
	logic            beyond;
	logic [RW-1:0]   ri_lo, ri_hi;

	assign e_full   = d_s2 - T_D;
	assign e        = e_full[EW-1:0];
	assign den      = DENW'(ONE_L[S-1:0]) + DENW'({e, 1'b0}) + DENW'(e);
	assign x        = {d_s2[F-2:0], 1'b0};
	assign pos      = PW'(d_s2) * PW'(D);
	assign idx_full = pos[PW-1:FRW];
	assign beyond   = idx_full >= IW'(D);
	assign ri_lo    = beyond ? RW'(D) : idx_full[RW-1:0];
	assign ri_hi    = beyond ? RW'(D) : ri_lo + RW'(1);

	logic            neg_s3, over_s3, big_s3, tsmall_s3;
	logic [DW-1:0]   d_s3;
	logic [NW-1:0]   num_s3;
	logic [DENW-1:0] den_s3;
	logic [F-1:0]    x_s3;
	logic [2*F-1:0]  xx_s3;
	logic [S-1:0]    lo_s3, hi_s3;
	logic [FRW-1:0]  fr_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			neg_s3    <= neg_s2;
			d_s3      <= d_s2;
			over_s3   <= d_s2 > T_D;
			big_s3    <= (d_s2 > T_D) && (e_full >= BIG_D);
			num_s3    <= (NW'(e) << F) + NW'(den >> 1);
			den_s3    <= den;
			tsmall_s3 <= d_s2 < HALF_D;
			x_s3      <= x;
			xx_s3     <= (2*F)'(x) * (2*F)'(x);
			lo_s3     <= TANH_ROM[ri_lo*S +: S];
			hi_s3     <= TANH_ROM[ri_hi*S +: S];
			fr_s3     <= pos[FRW-1:0];
		end
	end

	// s4: tube cube product, tape interpolation product
	logic [2*F:0] x2sum;
	logic [F:0]   x2;
	logic [S-1:0] diff;

	assign x2sum = {1'b0, xx_s3} + (2*F+1)'(ONE_L >> 1);
	assign x2    = x2sum[2*F:F];
	assign diff  = (hi_s3 > lo_s3) ? hi_s3 - lo_s3 : '0;

	logic            neg_s4, over_s4, big_s4, tsmall_s4;
	logic [DW-1:0]   d_s4;
	logic [NW-1:0]   num_s4;
	logic [DENW-1:0] den_s4;
	logic [F-1:0]    x_s4;
	logic [2*F:0]    x3p_s4;
	logic [S-1:0]    lo_s4;
	logic [TPW-1:0]  tp_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			neg_s4    <= neg_s3;
			d_s4      <= d_s3;
			over_s4   <= over_s3;
			big_s4    <= big_s3;
			num_s4    <= num_s3;
			den_s4    <= den_s3;
			tsmall_s4 <= tsmall_s3;
			x_s4      <= x_s3;
			x3p_s4    <= (2*F+1)'(x2) * (2*F+1)'(x_s3);
			lo_s4     <= lo_s3;
			tp_s4     <= TPW'(diff) * TPW'(fr_s3);
		end
	end

	// s5: divide by three through reciprocal, finish interpolation
	logic [2*F+1:0] x3sum;
	logic [F+1:0]   n3;

	assign x3sum = {1'b0, x3p_s4} + (2*F+2)'(ONE_L >> 1);
	assign n3    = x3sum[2*F+1:F] + (F+2)'(1);

	logic            neg_s5, over_s5, big_s5, tsmall_s5;
	logic [DW-1:0]   d_s5;
	logic [NW-1:0]   num_s5;
	logic [DENW-1:0] den_s5;
	logic [F-1:0]    x_s5;
	logic [P3W-1:0]  p3_s5;
	logic [S-1:0]    tm_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			neg_s5    <= neg_s4;
			d_s5      <= d_s4;
			over_s5   <= over_s4;
			big_s5    <= big_s4;
			num_s5    <= num_s4;
			den_s5    <= den_s4;
			tsmall_s5 <= tsmall_s4;
			x_s5      <= x_s4;
			p3_s5     <= P3W'(n3) * M3_P;
			tm_s5     <= lo_s4 + S'(tp_s4 >> FRW);
		end
	end

	// s6: pick the non-divider curve result, load the divider
	logic [P3W-1:0] q3;
	logic [DW-1:0]  tube_m, hard_m, other_m;

	assign q3     = p3_s5 >> K3;
	assign tube_m = tsmall_s5 ? DW'(x_s5) - DW'(q3) : TCAP_D;
	assign hard_m = (d_s5 < H_D) ? d_s5 : H_D;

	always_comb begin
		case (curve_mode_q)
			MODE_HARD: other_m = hard_m;
			MODE_TUBE: other_m = tube_m;
			MODE_TAPE: other_m = DW'(tm_s5);
			default:   other_m = d_s5;
		endcase
	end

	logic [NW-1:0]   dv_rem_s  [0:QB];
	logic [DENW-1:0] dv_den_s  [0:QB];
	logic [QB-1:0]   dv_quo_s  [0:QB];
	logic [DW-1:0]   dv_mo_s   [0:QB];
	logic            dv_neg_s  [0:QB];
	logic            dv_over_s [0:QB];
	logic            dv_big_s  [0:QB];

	always_ff @(posedge clk) begin
		if (en[6]) begin
			dv_rem_s[0]  <= num_s5;
			dv_den_s[0]  <= den_s5;
			dv_quo_s[0]  <= '0;
			dv_mo_s[0]   <= other_m;
			dv_neg_s[0]  <= neg_s5;
			dv_over_s[0] <= over_s5;
			dv_big_s[0]  <= big_s5;
		end
	end

	// soft knee divider, one quotient bit per stage, msb first
	for (genvar j = 1; j <= QB; j++) begin : g_div
		localparam int B = QB - j;
		logic [NW:0] sh;
		logic        take;

		assign sh   = (NW+1)'(dv_den_s[j-1]) << B;
		assign take = {1'b0, dv_rem_s[j-1]} >= sh;

		always_ff @(posedge clk) begin
			if (en[6+j]) begin
				dv_rem_s[j]  <= take ? dv_rem_s[j-1] - sh[NW-1:0] : dv_rem_s[j-1];
				dv_quo_s[j]  <= dv_quo_s[j-1] | (take ? QB'(1) << B : '0);
				dv_den_s[j]  <= dv_den_s[j-1];
				dv_mo_s[j]   <= dv_mo_s[j-1];
				dv_neg_s[j]  <= dv_neg_s[j-1];
				dv_over_s[j] <= dv_over_s[j-1];
				dv_big_s[j]  <= dv_big_s[j-1];
			end
		end
	end

	// output stage: soft knee select and clamp to minus one or just below plus one
	logic [DW-1:0] m_fin, m_cl;

	always_comb begin
		m_fin = dv_mo_s[QB];
		if (curve_mode_q == MODE_SOFT && dv_over_s[QB]) begin
			m_fin = dv_big_s[QB] ? ONE_D : T_D + DW'(dv_quo_s[QB]);
		end
		if (dv_neg_s[QB]) m_cl = (m_fin > ONE_D) ? ONE_D : m_fin;
		else m_cl = (m_fin > MAX_D) ? MAX_D : m_fin;
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			sample_out <= dv_neg_s[QB] ? -$signed(m_cl[S-1:0]) : $signed(m_cl[S-1:0]);
		end
	end

	`include "multi_mode_saturation_waveshaper_unit_assert.svh"

	`MMSW_ASSERT_SAME(a_empty_out_frees_in, !out_valid, !in_stall)
	`MMSW_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, vld_q[1])
	`MMSW_ASSERT_NEXT(a_last_moves_out, vld_q[NST-1] && en[NST], out_valid)
	`MMSW_ASSERT_SAME(a_hard_clip_bound, out_valid && curve_mode_q == MODE_HARD,
		sample_out <= HPOS_S && sample_out >= HNEG_S)

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// drives audio samples through the saturation waveshaper in every curve
// mode and at several drive gains, and checks each output beat against a
// bit-exact integer model of the drive, the curves and the final clamp
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import mmsw_pkg::*;

	localparam int SB    = 16;
	localparam int FB    = SB - 1;
	localparam int DEPTH = 256;
	localparam longint UNIT = 64'd1 << FB;
	localparam int LATENCY = 7 + FB;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SB-1:0] sample_in = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic signed [SB-1:0] sample_out;
	logic cfg_we = 1'b0;
	reg_idx_t cfg_addr = REG_CURVE_MODE;
	logic [CFG_W-1:0] cfg_wdata = '0;

	always #5 clk = ~clk;

	multi_mode_saturation_waveshaper_unit #(
		.SAMPLE_BITS(SB), .TANH_TABLE_DEPTH(DEPTH)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
		.out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// shaper settings as the model sees them
	mode_t  cur_mode = MODE_SOFT;
	gain_t  cur_gain = GAIN_UNITY;
	longint unsigned tanh_tab [0:DEPTH];

	logic [SB-1:0] pending_samples [$];
	logic [SB-1:0] expected_samples [$];
	int errors = 0;
	int accepted = 0;
	int hold_off = 0;
	bit hold_req = 0;
	bit hold_done = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic void build_tanh_table();
		longint unsigned a, term, r, p, num, den, t30, v30;
		a = (64'd12 << 31) / DEPTH;
		term = 64'd1 << 31;
		r = term;
		p = term;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * a) >> 31) / k;
			if (k & 1) r = r - term;
			else r = r + term;
		end
		for (int i = 0; i <= DEPTH; i++) begin
			num = (64'd1 << 31) - p;
			den = (64'd1 << 31) + p;
			t30 = (num << 30) / den;
			v30 = (t30 * 4 + 2) / 5;
			tanh_tab[i] = ((v30 << FB) + (64'd1 << 29)) >> 30;
			p = (p * r + (64'd1 << 30)) >> 31;
		end
	endfunction

	function automatic logic [SB-1:0] shape_sample(input logic [SB-1:0] raw);
		longint unsigned mag, d, m, t, e, den, x, x2, x3, pos, idx, fr, lo, hi, diff;
		bit neg;
		neg = raw[SB-1];
		mag = neg ? ((64'd1 << SB) - raw) : raw;
		d = (mag * cur_gain + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
		case (cur_mode)
			MODE_SOFT: begin
				t = (7 * UNIT + 5) / 10;
				if (d <= t) m = d;
				else begin
					e = d - t;
					if (e >= 3 * UNIT) m = UNIT;
					else begin
						den = UNIT + 3 * e;
						m = t + (e * UNIT + den / 2) / den;
					end
				end
			end
			MODE_HARD: begin
				t = (19 * UNIT + 10) / 20;
				m = d < t ? d : t;
			end
			MODE_TUBE: begin
				x = 2 * d;
				if (x >= UNIT) m = (2 * UNIT + 1) / 3;
				else begin
					x2 = (x * x + UNIT / 2) >> FB;
					x3 = (x2 * x + UNIT / 2) >> FB;
					m = x - (x3 + 1) / 3;
				end
			end
			MODE_TAPE: begin
				pos = d * DEPTH;
				idx = pos >> (FB + 2);
				fr = pos & ((64'd1 << (FB + 2)) - 1);
				if (idx >= DEPTH) m = tanh_tab[DEPTH];
				else begin
					lo = tanh_tab[idx];
					hi = tanh_tab[idx + 1];
					diff = hi > lo ? hi - lo : 0;
					m = lo + ((diff * fr) >> (FB + 2));
				end
			end
			default: m = d;
		endcase
		if (neg) begin
			if (m > UNIT) m = UNIT;
			return SB'(64'd0 - m);
		end
		if (m > UNIT - 1) m = UNIT - 1;
		return SB'(m);
	endfunction

	// driver: a random gap may follow each beat
	int gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_samples.push_back(shape_sample(sample_in));
				accepted++;
			end
			if (in_valid && in_stall) begin
				// payload held
			end else if (gap > 0) begin
				in_valid <= 1'b0;
				gap <= gap - 1;
			end else if (pending_samples.size() > 0) begin
				in_valid <= 1'b1;
				sample_in <= pending_samples.pop_front();
				gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted on its own
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_off <= 120;
			hold_done <= 1'b1;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
		end
	end

	// monitor and receiver stall
	int stall_cnt = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0)
					report($sformatf("unexpected beat %0d", sample_out));
				else begin
					logic [SB-1:0] want;
					want = expected_samples.pop_front();
					if (sample_out !== want)
						report($sformatf("sample_out %h expected %h", sample_out, want));
				end
			end
			if (hold_off > 0) begin
				out_stall <= 1'b1;
			end else if (stall_cnt > 0) begin
				out_stall <= 1'b1;
				stall_cnt <= stall_cnt - 1;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0) stall_cnt <= $urandom_range(0, 14);
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CURVE_MODE) cur_mode = mode_t'(val);
		else cur_gain = gain_t'(val);
	endtask

	task automatic drain();
		int target;
		target = accepted + pending_samples.size();
		while (pending_samples.size() > 0 || in_valid || accepted < target
			|| expected_samples.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [SB-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return SB'($urandom_range(0, 64));
			1: return -SB'($urandom_range(0, 64));
			2: return 16'h8000 + SB'($urandom_range(0, 64));
			3: return 16'h7fff - SB'($urandom_range(0, 64));
			default: return SB'($urandom);
		endcase
	endfunction

	initial begin
		logic [CFG_W-1:0] gains [6];
		build_tanh_table();
		gains = '{16'd4096, 16'd0, 16'd65535, 16'd1, 16'd2048, 16'd12000};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// directed extremes at reset settings, then every mode
		for (int md = 0; md < 8; md++) begin
			if (md > 0) write_reg(REG_CURVE_MODE, CFG_W'(md));
			pending_samples.push_back(16'h0000);
			pending_samples.push_back(16'h7fff);
			pending_samples.push_back(16'h8000);
			pending_samples.push_back(16'h0001);
			pending_samples.push_back(16'hffff);
			pending_samples.push_back(16'h5999);
			pending_samples.push_back(16'ha667);
			drain();
		end
		// random phases over modes and gains
		for (int ph = 0; ph < 24; ph++) begin
			write_reg(REG_CURVE_MODE, CFG_W'(ph % 5 == 4 ? $urandom_range(4, 7) : ph % 5));
			write_reg(REG_DRIVE_GAIN, ph < 6 ? gains[ph] : CFG_W'($urandom));
			for (int n = 0; n < 62; n++) pending_samples.push_back(rand_sample());
			if (ph == 3) hold_req = 1'b1;
			drain();
		end
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

endmodule
